// File: design/nci_pkg.sv
// Package for the neighbor cache insert block: transaction structs, scan token,
// write-back command and the link address byte mask. No dependencies.
`timescale 1ns / 1ps

package nci_pkg;

    localparam int ENTRIES = 8;
    localparam int SLOT_W  = 6;

    typedef struct packed {
        logic [63:0] ip_hi;
        logic [63:0] ip_lo;
        logic [7:0]  link_type;
        logic [3:0]  link_size;
        logic [63:0] link_addr;
        logic [3:0]  device_id;
        logic [31:0] now;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              deleted_old;
        logic              announce_new;
        logic [63:0]       old_ip_hi;
        logic [63:0]       old_ip_lo;
        logic [7:0]        old_link_type;
        logic [63:0]       old_link_addr;
    } t_out;

    typedef struct packed {
        logic [63:0] ip_hi;
        logic [63:0] ip_lo;
        logic [7:0]  link_type;
        logic [3:0]  link_size;
        logic [63:0] link_addr;
        logic [3:0]  device;
        logic [31:0] etime;
    } t_entry;

    // scan token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              have;
        logic              found;
        logic [SLOT_W-1:0] sel;
        t_entry            cand;
    } t_scan;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] sel;
        t_in               req;
    } t_wr;

    function automatic logic [63:0] byte_mask(input logic [3:0] size);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if ((size > 4'(b)) || (size >= 4'd8)) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// File: design/nci_cell.sv
// One table cell of the neighbor cache: holds one entry, updates the scan
// token passing through it and takes the write-back. Depends on nci_pkg.
`timescale 1ns / 1ps

module nci_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [nci_pkg::SLOT_W-1:0] i_idx,
    input  nci_pkg::t_in              i_req,
    input  nci_pkg::t_scan            i_scan,
    input  logic                      i_hold,
    input  nci_pkg::t_wr              i_wr,
    output nci_pkg::t_scan            o_scan
);

    nci_pkg::t_entry r_e;
    nci_pkg::t_entry n_e;
    nci_pkg::t_scan  r_scan;
    nci_pkg::t_scan  n_scan;
    logic            match;
    logic [31:0]     tdiff;
    logic [63:0]     wmask;

    assign match = (r_e.link_type == i_req.link_type) && (r_e.ip_hi == i_req.ip_hi)
                   && (r_e.ip_lo == i_req.ip_lo);
    assign tdiff = r_e.etime - i_scan.cand.etime;

    always_comb begin
        n_scan = i_scan;
        if (i_scan.valid && !i_scan.found) begin
            if (!i_scan.have || match || tdiff[31]) begin
                n_scan.have  = 1'b1;
                n_scan.found = match;
                n_scan.sel   = i_idx;
                n_scan.cand  = r_e;
            end
        end
    end

    always_comb begin
        wmask       = nci_pkg::byte_mask(i_wr.req.link_size);
        n_e         = r_e;
        if (i_wr.en && (i_wr.sel == i_idx)) begin
            n_e.ip_hi     = i_wr.req.ip_hi;
            n_e.ip_lo     = i_wr.req.ip_lo;
            n_e.link_type = i_wr.req.link_type;
            n_e.link_size = i_wr.req.link_size;
            n_e.link_addr = (r_e.link_addr & ~wmask) | (i_wr.req.link_addr & wmask);
            n_e.device    = i_wr.req.device_id;
            n_e.etime     = i_wr.req.now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e    <= '0;
            r_scan <= '0;
        end else begin
            r_e <= n_e;
            if (!(i_hold && r_scan.valid)) begin
                r_scan <= n_scan;
            end
        end
    end

    assign o_scan = r_scan;

endmodule

// File: design/neighbor_cache_insert_oldest_replace.sv
// Top level of the neighbor cache insert: request register, row of table
// cells, result build and write-back. Depends on nci_pkg and nci_cell.
//
//   channel | direction | payload          | handshake
//   in      | input     | nci_pkg::t_in    | i_in_valid / o_in_stall
//   out     | output    | nci_pkg::t_out   | o_out_valid / i_out_stall
//
// The scan token steps through one cell per cycle (only the last cell can hold
// it), then the result is registered and the chosen cell written in the same
// edge. The stall drops at that edge, so the next request can be taken in the
// cycle after. One insert is in flight at a time; an output stall on a waiting
// result holds the token in the last cell and delays the result and the write-back.
// A new request is taken while a finished result still waits on a stall.
// Reset clears the whole table at once.
`timescale 1ns / 1ps

module neighbor_cache_insert_oldest_replace (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  nci_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output nci_pkg::t_out o_out_data,
    input  logic          i_out_stall
);

    localparam int N = nci_pkg::ENTRIES;

    nci_pkg::t_in   r_req;
    logic           r_busy;
    logic           r_start;
    logic           r_o_valid;
    nci_pkg::t_out  r_o_data;
    nci_pkg::t_out  n_o_data;
    nci_pkg::t_scan scan_in [N+1];
    nci_pkg::t_scan last;
    nci_pkg::t_wr   wr;
    logic           in_acc;
    logic           out_free;
    logic           finish;
    logic [63:0]    cmask;

    assign in_acc   = i_in_valid && !r_busy;
    assign out_free = !r_o_valid || !i_out_stall;
    assign last     = scan_in[N];
    assign finish   = last.valid && out_free;

    always_comb begin
        scan_in[0]       = '0;
        scan_in[0].valid = r_start;
    end

    assign wr.en  = finish;
    assign wr.sel = last.sel;
    assign wr.req = r_req;

    for (genvar g = 0; g < N; g++) begin : g_cell
        nci_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (nci_pkg::SLOT_W'(g)),
            .i_req   (r_req),
            .i_scan  (scan_in[g]),
            .i_hold  ((g == N - 1) ? !out_free : 1'b0),
            .i_wr    (wr),
            .o_scan  (scan_in[g+1])
        );
    end

    always_comb begin
        cmask                  = nci_pkg::byte_mask(last.cand.link_size);
        n_o_data               = '0;
        n_o_data.slot          = last.sel;
        n_o_data.hit           = last.found;
        n_o_data.announce_new  = !last.found
                                 || ((last.cand.link_addr & cmask) != (r_req.link_addr & cmask));
        if (!last.found && (last.cand.etime != 32'd0)) begin
            n_o_data.deleted_old   = 1'b1;
            n_o_data.old_ip_hi     = last.cand.ip_hi;
            n_o_data.old_ip_lo     = last.cand.ip_lo;
            n_o_data.old_link_type = last.cand.link_type;
            n_o_data.old_link_addr = last.cand.link_addr & cmask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_start   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_start <= in_acc;
            if (in_acc) begin
                r_busy <= 1'b1;
                r_req  <= i_in_data;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (finish) begin
                r_o_valid <= 1'b1;
                r_o_data  <= n_o_data;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

// File: design/nci_chk.sv
// Port checker for the neighbor cache insert top level, bound to it below.
// Depends on nci_pkg and neighbor_cache_insert_oldest_replace.
`timescale 1ns / 1ps

module nci_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input nci_pkg::t_in  i_in_data,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input nci_pkg::t_out o_out_data,
    input logic          i_out_stall
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("no stall after accepted transaction");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without transaction in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    a_in_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> $stable(i_in_data))
        else $error("input payload changed while stalled");

endmodule

bind neighbor_cache_insert_oldest_replace nci_chk u_nci_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

// File: dv/nci_insert_checker.sv
// Checker for the neighbor cache insert: keeps its own copy of the neighbor table,
// predicts each insert result and compares it with the output channel.
// Depends on nci_pkg.
`timescale 1ns / 1ps

module nci_insert_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  nci_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  nci_pkg::t_out i_out_data,
    output int            o_errors,
    output int            o_pending,
    output int            o_results,
    output int            o_hits,
    output int            o_evictions
);

    localparam int IDX_W = $clog2(nci_pkg::ENTRIES);

    nci_pkg::t_entry cache_tbl [nci_pkg::ENTRIES];
    nci_pkg::t_out   insert_q [$];
    nci_pkg::t_out   want;
    int              err_cnt;
    int              result_cnt;
    int              hit_cnt;
    int              evict_cnt;

    function automatic logic [63:0] size_mask(input logic [3:0] nbytes);
        if (nbytes >= 4'd8) begin
            return '1;
        end
        return (64'd1 << (8 * nbytes)) - 64'd1;
    endfunction

    // Scan for a match on link type + IP; else take the wrap-aware oldest slot.
    function automatic nci_pkg::t_out predict_insert(input nci_pkg::t_in req);
        nci_pkg::t_out    res;
        logic [IDX_W-1:0] sel;
        logic [31:0]      oldest;
        logic [31:0]      age;
        logic             found;
        logic [63:0]      old_mask;
        logic [63:0]      new_mask;
        res    = '0;
        sel    = '0;
        found  = 1'b0;
        oldest = cache_tbl[0].etime;
        for (int i = 0; i < nci_pkg::ENTRIES; i++) begin
            if (!found) begin
                if (cache_tbl[IDX_W'(i)].link_type == req.link_type &&
                    cache_tbl[IDX_W'(i)].ip_hi == req.ip_hi &&
                    cache_tbl[IDX_W'(i)].ip_lo == req.ip_lo) begin
                    sel   = IDX_W'(i);
                    found = 1'b1;
                end else begin
                    age = cache_tbl[IDX_W'(i)].etime - oldest;
                    if (age[31]) begin
                        sel    = IDX_W'(i);
                        oldest = cache_tbl[IDX_W'(i)].etime;
                    end
                end
            end
        end
        old_mask = size_mask(cache_tbl[sel].link_size);
        if (!found && cache_tbl[sel].etime != 32'd0) begin
            res.deleted_old   = 1'b1;
            res.old_ip_hi     = cache_tbl[sel].ip_hi;
            res.old_ip_lo     = cache_tbl[sel].ip_lo;
            res.old_link_type = cache_tbl[sel].link_type;
            res.old_link_addr = cache_tbl[sel].link_addr & old_mask;
        end
        res.announce_new = !found ||
                           (((cache_tbl[sel].link_addr ^ req.link_addr) & old_mask) != 0);
        res.slot         = nci_pkg::SLOT_W'(sel);
        res.hit          = found;

        new_mask                  = size_mask(req.link_size);
        cache_tbl[sel].link_addr  = (cache_tbl[sel].link_addr & ~new_mask) |
                                    (req.link_addr & new_mask);
        cache_tbl[sel].ip_hi      = req.ip_hi;
        cache_tbl[sel].ip_lo      = req.ip_lo;
        cache_tbl[sel].link_type  = req.link_type;
        cache_tbl[sel].link_size  = req.link_size;
        cache_tbl[sel].device     = req.device_id;
        cache_tbl[sel].etime      = req.now;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            if (err_cnt < 10) begin
                $display("ERROR result %0d: %s expected %h got %h",
                         result_cnt, name, want_v, got_v);
            end
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cache_tbl = '{default: '0};
            insert_q.delete();
            err_cnt     = 0;
            result_cnt  = 0;
            hit_cnt     = 0;
            evict_cnt   = 0;
            o_errors    <= 0;
            o_pending   <= 0;
            o_results   <= 0;
            o_hits      <= 0;
            o_evictions <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (insert_q.size() == 0) begin
                    if (err_cnt < 10) begin
                        $display("ERROR unexpected result transaction: slot %0d hit %b",
                                 i_out_data.slot, i_out_data.hit);
                    end
                    err_cnt++;
                end else begin
                    want = insert_q.pop_front();
                    check_field("slot", 64'(want.slot), 64'(i_out_data.slot));
                    check_field("hit", 64'(want.hit), 64'(i_out_data.hit));
                    check_field("deleted_old", 64'(want.deleted_old), 64'(i_out_data.deleted_old));
                    check_field("announce_new", 64'(want.announce_new),
                                64'(i_out_data.announce_new));
                    check_field("old_ip_hi", want.old_ip_hi, i_out_data.old_ip_hi);
                    check_field("old_ip_lo", want.old_ip_lo, i_out_data.old_ip_lo);
                    check_field("old_link_type", 64'(want.old_link_type),
                                64'(i_out_data.old_link_type));
                    check_field("old_link_addr", want.old_link_addr, i_out_data.old_link_addr);
                    hit_cnt   += want.hit;
                    evict_cnt += want.deleted_old;
                end
                result_cnt++;
            end
            if (i_in_valid && !i_in_stall) begin
                insert_q.push_back(predict_insert(i_in_data));
            end
            o_errors    <= err_cnt;
            o_pending   <= insert_q.size();
            o_results   <= result_cnt;
            o_hits      <= hit_cnt;
            o_evictions <= evict_cnt;
        end
    end

endmodule

// File: dv/neighbor_cache_insert_oldest_replace_tb.sv
// Testbench top for the neighbor cache insert: clock, reset, insert stimulus
// and output stalls, watchdog and verdict. Depends on nci_pkg, the block and
// nci_insert_checker.
`timescale 1ns / 1ps

module neighbor_cache_insert_oldest_replace_tb;

    localparam int IDLE_LIMIT = 4000;
    localparam int KEYS       = 12;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    nci_pkg::t_in  i_in_data   = '0;
    logic          i_out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    nci_pkg::t_out o_out_data;

    int            err_total;
    int            pending_cnt;
    int            result_cnt;
    int            hit_cnt;
    int            evict_cnt;
    int            idle_cycles = 0;
    int            stall_left  = 0;
    int            stall_len;
    logic          quiet = 1'b0;

    nci_pkg::t_in  stim_q [$];
    logic [63:0]   key_hi   [KEYS];
    logic [63:0]   key_lo   [KEYS];
    logic [7:0]    key_type [KEYS];
    logic [63:0]   key_addr [KEYS];

    always #10 i_clk = ~i_clk;

    neighbor_cache_insert_oldest_replace dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    nci_insert_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .o_errors    (err_total),
        .o_pending   (pending_cnt),
        .o_results   (result_cnt),
        .o_hits      (hit_cnt),
        .o_evictions (evict_cnt)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic nci_pkg::t_in insert_req(input logic [63:0] ip_hi, input logic [63:0] ip_lo,
                                                input logic [7:0] ltype, input logic [3:0] lsize,
                                                input logic [63:0] laddr, input logic [3:0] dev,
                                                input logic [31:0] now);
        nci_pkg::t_in req;
        req.ip_hi     = ip_hi;
        req.ip_lo     = ip_lo;
        req.link_type = ltype;
        req.link_size = lsize;
        req.link_addr = laddr;
        req.device_id = dev;
        req.now       = now;
        return req;
    endfunction

    // output side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_len = quiet ? 0 : idle_len();
            i_out_stall <= (stall_len > 0);
            stall_left  <= (stall_len > 0) ? stall_len - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int          k;
        int          g;
        int          r;
        int          kx;
        logic [31:0] tick;
        logic [31:0] now;

        // directed: all-zero key hits a cleared slot, no new notice
        stim_q.push_back(insert_req('0, '0, 8'h00, 4'd5, 64'h0000_1122_3344_5566, 4'd3, 32'd100));
        // field maxima, oversize link length
        stim_q.push_back(insert_req('1, '1, 8'hFF, 4'hF, '1, 4'hF, 32'hFFFF_FFFF));
        // hit with changed address, partial write of two bytes
        stim_q.push_back(insert_req('1, '1, 8'hFF, 4'd2, 64'h0000_0000_0000_ABCD, 4'd1, 32'd200));
        // hit, same bytes within stored size
        stim_q.push_back(insert_req('1, '1, 8'hFF, 4'd9, 64'hFFFF_FFFF_FFFF_ABCD, 4'd2, 32'd201));
        // same IP, other link type: miss
        stim_q.push_back(insert_req('1, '1, 8'hFE, 4'd8, 64'h0102_0304_0506_0708, 4'd4, 32'd202));
        // zero time leaves the slot looking unused
        stim_q.push_back(insert_req(64'h2001_0DB8_0000_0001, 64'h1, 8'h06, 4'd6,
                                    64'h0000_AABB_CCDD_EEFF, 4'd7, 32'd0));
        // fill past capacity with times crossing the signed wrap point
        for (k = 0; k < 10; k++) begin
            stim_q.push_back(insert_req(64'hFE80_0000_0000_0000, 64'(k), 8'h01, 4'd6,
                                        {$urandom, $urandom}, 4'(k), 32'h7FFF_FFF8 + 32'(3 * k)));
        end
        // time wrapped past zero
        stim_q.push_back(insert_req(64'hFE80_0000_0000_0000, 64'd20, 8'h01, 4'd6,
                                    64'h0000_1111_2222_3333, 4'd8, 32'd5));
        // re-hit, size zero: no address bytes written
        stim_q.push_back(insert_req(64'hFE80_0000_0000_0000, 64'd20, 8'h01, 4'd0,
                                    64'h0000_9999_8888_7777, 4'd9, 32'd6));
        // re-hit, stored size zero, new address
        stim_q.push_back(insert_req(64'hFE80_0000_0000_0000, 64'd20, 8'h01, 4'd8,
                                    64'h8000_0000_0000_0001, 4'd10, 32'd7));
        // oldest key again, likely evicted
        stim_q.push_back(insert_req(64'hFE80_0000_0000_0000, 64'd0, 8'h01, 4'd3,
                                    64'h0000_0000_00DE_ADBE, 4'd11, 32'd8));
        // equal times: lowest index wins
        stim_q.push_back(insert_req(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 4'd7,
                                    64'h00FF_00FF_00FF_00FF, 4'd12, 32'd8));

        for (kx = 0; kx < KEYS; kx++) begin
            key_hi[kx]   = {$urandom, $urandom};
            key_lo[kx]   = {$urandom, $urandom};
            key_type[kx] = 8'($urandom_range(0, 255));
            key_addr[kx] = {$urandom, $urandom};
        end
        // keys that share an IP with another key but not its link type
        key_hi[10]   = key_hi[0];
        key_lo[10]   = key_lo[0];
        key_type[10] = key_type[0] ^ 8'h01;
        key_hi[11]   = key_hi[1];
        key_lo[11]   = key_lo[1];
        key_type[11] = key_type[1] ^ 8'h80;

        tick = $urandom;
        for (k = 0; k < 1350; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                tick = $urandom;
            end else begin
                tick = tick + 32'($urandom_range(0, 40));
            end
            now = (r == 99) ? 32'd0 : tick;
            kx = $urandom_range(0, KEYS - 1);
            if ($urandom_range(0, 1) == 1) begin
                key_addr[kx] = {$urandom, $urandom};
            end
            r = $urandom_range(0, 99);
            if (r < 78) begin
                stim_q.push_back(insert_req(key_hi[kx], key_lo[kx], key_type[kx],
                                            4'($urandom_range(0, 15)), key_addr[kx],
                                            4'($urandom_range(0, 15)), now));
            end else if (r < 80) begin
                stim_q.push_back(insert_req('0, '0, 8'h00, 4'($urandom_range(0, 15)),
                                            {$urandom, $urandom}, 4'($urandom_range(0, 15)), now));
            end else begin
                stim_q.push_back(insert_req({$urandom, $urandom}, {$urandom, $urandom},
                                            8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                                            {$urandom, $urandom}, 4'($urandom_range(0, 15)), now));
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < stim_q.size(); k++) begin
            quiet <= ((k / 150) % 3 == 2);
            g = ((k / 150) % 3 == 2) ? 0 : idle_len();
            if (g > 0) begin
                i_in_valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= stim_q[k];
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
        end
        i_in_valid <= 1'b0;
        quiet      <= 1'b0;

        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Sent %0d inserts, checked %0d results: %0d hits, %0d evictions",
                 stim_q.size(), result_cnt, hit_cnt, evict_cnt);
        $display("Covered cleared-slot hits, oversize and partial link writes, wrapped times");
        if (err_total == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("Mismatches: %0d", err_total);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
